>>> hdl/rsf_pkg.sv
// Shared types and constants of the RISC-V return site finder.
package rsf_pkg;

    // Width of the running byte offset; offsets wrap at this width.
    localparam int OFFSET_BITS = 20;

    // Widths fixed by the stream fields.
    localparam int HALF_BITS   = 16;
    localparam int SIZE_BITS   = 20;
    localparam int RET_BITS    = 20;
    localparam int KIND_BITS   = 2;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 24;

    // Displacement widths of JAL and C.J.
    localparam int JAL_IMM_BITS = 21;
    localparam int CJ_IMM_BITS  = 12;

    // Target arithmetic: wide enough for offset plus a signed displacement, with sign.
    localparam int TGT_BITS =
        ((OFFSET_BITS > JAL_IMM_BITS) ? OFFSET_BITS : JAL_IMM_BITS) + 2;

    // Opcode matching constants.
    localparam logic [6:0]  OPC_JAL    = 7'h6f;
    localparam logic [31:0] MASK_JALR  = 32'h0000_707f;
    localparam logic [31:0] MATCH_JALR = 32'h0000_0067;
    localparam logic [15:0] MASK_CJ    = 16'he003;
    localparam logic [15:0] MATCH_CJ   = 16'ha001;
    localparam logic [15:0] MASK_CJR   = 16'hf07f;
    localparam logic [15:0] MATCH_CJR  = 16'h8002;
    localparam logic [4:0]  REG_RA     = 5'd1;
    localparam logic [4:0]  REG_ZERO   = 5'd0;

    // Offset increments per instruction size.
    localparam logic [2:0] STEP_NONE = 3'd0;
    localparam logic [2:0] STEP_HALF = 3'd2;
    localparam logic [2:0] STEP_WORD = 3'd4;

    typedef enum logic [KIND_BITS-1:0] {
        KIND_JAL  = 2'd0,
        KIND_JALR = 2'd1,
        KIND_CJ   = 2'd2,
        KIND_CJR  = 2'd3
    } t_exit_kind;

    // Outcome of decoding one halfword against the held state.
    typedef struct packed {
        logic       hit;       // the instruction leaves the function
        t_exit_kind kind;      // which exit it is
        logic       hold_low;  // halfword opens a 32-bit instruction
        logic [2:0] step;      // bytes the offset moves by
    } t_dec_res;

endpackage

>>> hdl/rsf_decode.sv
// Instruction decode and jump target check for one code halfword.
module rsf_decode (
    input  logic [rsf_pkg::HALF_BITS-1:0]   i_half,
    input  logic [rsf_pkg::HALF_BITS-1:0]   i_low_half,
    input  logic                            i_pending,
    input  logic [rsf_pkg::OFFSET_BITS-1:0] i_at,
    input  logic [rsf_pkg::SIZE_BITS-1:0]   i_func_size,
    output rsf_pkg::t_dec_res               o_res
);

    localparam int TW = rsf_pkg::TGT_BITS;

    logic [31:0]                          word;
    logic [rsf_pkg::JAL_IMM_BITS-1:0]     jal_imm;
    logic [rsf_pkg::CJ_IMM_BITS-1:0]      cj_imm;
    logic [rsf_pkg::JAL_IMM_BITS-1:0]     disp;
    logic [TW-1:0]                        target;
    logic                                 outside;
    logic                                 is_jal;
    logic                                 is_jalr;
    logic                                 is_cj;
    logic                                 is_cjr;

    assign word = {i_half, i_low_half};

    assign jal_imm = {word[31], word[19:12], word[20], word[30:21], 1'b0};
    assign cj_imm  = {i_half[12], i_half[8], i_half[10:9], i_half[6], i_half[7],
                      i_half[2], i_half[11], i_half[5:3], 1'b0};

    // Only one of the two displacements is live for a given halfword.
    assign disp = i_pending ? jal_imm
        : {{(rsf_pkg::JAL_IMM_BITS - rsf_pkg::CJ_IMM_BITS){cj_imm[rsf_pkg::CJ_IMM_BITS-1]}},
           cj_imm};

    assign target = {{(TW - rsf_pkg::OFFSET_BITS){1'b0}}, i_at}
                  + {{(TW - rsf_pkg::JAL_IMM_BITS){disp[rsf_pkg::JAL_IMM_BITS-1]}}, disp};

    // Negative targets lie outside as well.
    assign outside = target[TW-1]
        || (target[TW-2:0] >= {{(TW - 1 - rsf_pkg::SIZE_BITS){1'b0}}, i_func_size});

    assign is_jal  = (word[6:0] == rsf_pkg::OPC_JAL);
    assign is_jalr = ((word & rsf_pkg::MASK_JALR) == rsf_pkg::MATCH_JALR);
    assign is_cj   = ((i_half & rsf_pkg::MASK_CJ) == rsf_pkg::MATCH_CJ);
    assign is_cjr  = ((i_half & rsf_pkg::MASK_CJR) == rsf_pkg::MATCH_CJR)
                  && (i_half[11:7] != rsf_pkg::REG_ZERO);

    always_comb begin
        o_res.hit      = 1'b0;
        o_res.kind     = rsf_pkg::KIND_JAL;
        o_res.hold_low = 1'b0;
        o_res.step     = rsf_pkg::STEP_NONE;
        if (i_pending) begin
            o_res.step = rsf_pkg::STEP_WORD;
            if (is_jal) begin
                o_res.hit  = (word[11:7] != rsf_pkg::REG_RA) && outside;
                o_res.kind = rsf_pkg::KIND_JAL;
            end else if (is_jalr) begin
                o_res.hit  = (word[11:7] != rsf_pkg::REG_RA)
                          || (word[19:15] == rsf_pkg::REG_RA);
                o_res.kind = rsf_pkg::KIND_JALR;
            end
        end else if (i_half[1:0] == 2'b11) begin
            o_res.hold_low = 1'b1;
        end else begin
            o_res.step = rsf_pkg::STEP_HALF;
            if (is_cj) begin
                o_res.hit  = outside;
                o_res.kind = rsf_pkg::KIND_CJ;
            end else if (is_cjr) begin
                o_res.hit  = 1'b1;
                o_res.kind = rsf_pkg::KIND_CJR;
            end
        end
    end

endmodule

>>> hdl/riscv_return_site_finder.sv
// Top level of the RISC-V return site finder: stream handshakes, state and result register.
//
// The block takes a function's code as one 16-bit halfword per request on the slave stream,
// tuser[0] marking the first halfword of a function, and sends one request on the master
// stream for every instruction that leaves the function (a JAL that does not link to x1 and
// jumps outside [0, func_size), a C.J jumping outside that range, a JALR that does not link
// to x1 or jumps through x1, and a C.JR through any register other than x0).
// It sustains one halfword per clock cycle while results are taken; the figure is set by the
// single decode and target compare stage between the input register and the result register.
// Results are registered in the result register, which drives the master stream, and a result
// held by the receiver stalls the input side until it is taken. Halfwords that produce no
// exit produce no output request. The func_size register is written through the cfg channel,
// which is always ready, and must only be changed while the block is idle.
module riscv_return_site_finder (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Configuration write channel: func_size.
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [rsf_pkg::SIZE_BITS-1:0]     i_cfg_data,
    // Code halfwords in.
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [rsf_pkg::IN_TDATA_W-1:0]    i_s_tdata,   // [15:0] half
    input  logic [0:0]                        i_s_tuser,   // [0] first
    // Exit sites out.
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [rsf_pkg::OUT_TDATA_W-1:0]   o_m_tdata,   // [19:0] ret_offset, [23:20] zero
    output logic [rsf_pkg::KIND_BITS-1:0]     o_m_tuser    // [1:0] exit_kind
);

    localparam int OB = rsf_pkg::OFFSET_BITS;
    localparam int RB = rsf_pkg::RET_BITS;

    // Configuration.
    logic [rsf_pkg::SIZE_BITS-1:0] r_func_size;

    // Input register.
    logic                          r_in_valid;
    logic [rsf_pkg::HALF_BITS-1:0] r_in_half;
    logic                          r_in_first;

    // Decode state.
    logic [OB-1:0]                 r_offset;
    logic                          r_pending;
    logic [rsf_pkg::HALF_BITS-1:0] r_low_half;

    // Result register.
    logic                          r_out_valid;
    logic [RB-1:0]                 r_out_offset;
    rsf_pkg::t_exit_kind           r_out_kind;

    logic                          advance;
    logic                          in_accept;
    logic [OB-1:0]                 at;
    logic                          pending;
    logic [OB-1:0]                 n_offset;
    logic [RB+OB-1:0]              at_ext;
    rsf_pkg::t_dec_res             dec;

    // The result register frees itself as it is taken, so the input stage can move on
    // in the same cycle as the output request completes.
    assign advance   = r_in_valid && (!r_out_valid || i_m_tready);
    assign in_accept = i_s_tvalid && o_s_tready;

    assign o_s_tready  = !r_in_valid || advance;
    assign o_cfg_ready = 1'b1;

    // A first halfword restarts the offset and drops any half-assembled instruction.
    assign at      = r_in_first ? '0 : r_offset;
    assign pending = r_in_first ? 1'b0 : r_pending;

    rsf_decode u_decode (
        .i_half      (r_in_half),
        .i_low_half  (r_low_half),
        .i_pending   (pending),
        .i_at        (at),
        .i_func_size (r_func_size),
        .o_res       (dec)
    );

    assign n_offset = at + {{(OB - 3){1'b0}}, dec.step};

    // The reported offset is the low bits of the running offset, zero-extended if narrower.
    assign at_ext = {{RB{1'b0}}, at};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_func_size <= '0;
            r_in_valid  <= 1'b0;
            r_offset    <= '0;
            r_pending   <= 1'b0;
            r_low_half  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_func_size <= i_cfg_data;
            end

            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end

            if (advance) begin
                r_offset    <= dec.hold_low ? at : n_offset;
                r_pending   <= dec.hold_low;
                if (dec.hold_low) begin
                    r_low_half <= r_in_half;
                end
                r_out_valid <= dec.hit;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_half  <= i_s_tdata[rsf_pkg::HALF_BITS-1:0];
            r_in_first <= i_s_tuser[0];
        end
        if (advance && dec.hit) begin
            r_out_offset <= at_ext[RB-1:0];
            r_out_kind   <= dec.kind;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(rsf_pkg::OUT_TDATA_W - RB){1'b0}}, r_out_offset};
    assign o_m_tuser  = r_out_kind;

endmodule

>>> hdl/rsf_checker.sv
// Port-level checks of the RISC-V return site finder, bound to its top level.
module rsf_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_s_tvalid,
    input logic                            o_s_tready,
    input logic                            o_m_tvalid,
    input logic                            i_m_tready,
    input logic [rsf_pkg::OUT_TDATA_W-1:0] o_m_tdata,
    input logic [rsf_pkg::KIND_BITS-1:0]   o_m_tuser
);

    // A stalled output request keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("stalled exit request changed");

    // The padding above the offset stays clear.
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[rsf_pkg::OUT_TDATA_W-1:rsf_pkg::RET_BITS] == '0))
        else $error("padding bits set in exit request");

    // With the result register empty the input side must never stall.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input stalled while output empty");

    // A newly appearing result comes from a halfword passed through the input and result registers.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(i_s_tvalid && o_s_tready, 2))
        else $error("exit request without matching input");

endmodule

bind riscv_return_site_finder rsf_checker u_rsf_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

>>> tb/tb_riscv_return_site_finder.sv
// Self-checking testbench of the RISC-V return site finder, with its own exit predictor.
module tb_riscv_return_site_finder;
    timeunit 1ns;
    timeprecision 1ps;

    // Widths used in casts.
    localparam int OFF_W  = rsf_pkg::OFFSET_BITS;
    localparam int RET_W  = rsf_pkg::RET_BITS;
    localparam int SIZE_W = rsf_pkg::SIZE_BITS;

    // Run length guard, mismatch print cap and settling time after the last result.
    localparam int unsigned LIMIT_CYCLES = 200_000;
    localparam int MAX_SHOWN = 40;
    localparam int SETTLE_CYCLES = 4;
    localparam int PHASE_ITEMS = 500;
    localparam int BLOCK_ITEMS = 100;

    // One exit site as the block should report it.
    typedef struct packed {
        logic                        hit;
        logic [rsf_pkg::RET_BITS-1:0] off;
        rsf_pkg::t_exit_kind         kind;
    } t_exit_site;

    // A generated instruction: 16 or 32 bits of code.
    typedef struct packed {
        logic        wide;
        logic [31:0] word;
    } t_insn;

    // A row of the directed table. Where typed is set, the expected outcome (hit, off, kind)
    // is the one written in the row; otherwise the predictor decides.
    typedef struct packed {
        logic [rsf_pkg::HALF_BITS-1:0] half;
        logic                          first;
        logic                          set_sz;
        logic [rsf_pkg::SIZE_BITS-1:0] sz;
        logic                          typed;
        logic                          hit;
        logic [rsf_pkg::RET_BITS-1:0]  off;
        rsf_pkg::t_exit_kind           kind;
    } t_row;

    localparam t_row DIRECTED [25] = '{
        // C.JR ra at the start of a function, after reset (size 0).
        '{16'h8082, 1'b1, 1'b0, 20'h0, 1'b1, 1'b1, 20'd0,  rsf_pkg::KIND_CJR},
        // C.JR x0 is reserved and never an exit.
        '{16'h8002, 1'b0, 1'b0, 20'h0, 1'b1, 1'b0, 20'd0,  rsf_pkg::KIND_JAL},
        // C.J to itself: with a zero size every target lies outside.
        '{16'ha001, 1'b0, 1'b0, 20'h0, 1'b1, 1'b1, 20'd4,  rsf_pkg::KIND_CJ},
        // JAL x0, 0: outside for the same reason.
        '{16'h006f, 1'b0, 1'b0, 20'h0, 1'b1, 1'b0, 20'd0,  rsf_pkg::KIND_JAL},
        '{16'h0000, 1'b0, 1'b0, 20'h0, 1'b1, 1'b1, 20'd6,  rsf_pkg::KIND_JAL},
        // JAL ra is a call, not an exit.
        '{16'h00ef, 1'b0, 1'b0, 20'h0, 1'b1, 1'b0, 20'd0,  rsf_pkg::KIND_JAL},
        '{16'h0000, 1'b0, 1'b0, 20'h0, 1'b1, 1'b0, 20'd0,  rsf_pkg::KIND_JAL},
        // JALR x0, 0(ra): the plain return.
        '{16'h8067, 1'b0, 1'b0, 20'h0, 1'b1, 1'b0, 20'd0,  rsf_pkg::KIND_JAL},
        '{16'h0000, 1'b0, 1'b0, 20'h0, 1'b1, 1'b1, 20'd14, rsf_pkg::KIND_JALR},
        // JALR ra, 0(ra): links to ra but jumps through it.
        '{16'h80e7, 1'b0, 1'b0, 20'h0, 1'b1, 1'b0, 20'd0,  rsf_pkg::KIND_JAL},
        '{16'h0000, 1'b0, 1'b0, 20'h0, 1'b1, 1'b1, 20'd18, rsf_pkg::KIND_JALR},
        // JALR ra, 0(t0): an indirect call.
        '{16'h80e7, 1'b0, 1'b0, 20'h0, 1'b1, 1'b0, 20'd0,  rsf_pkg::KIND_JAL},
        '{16'h0002, 1'b0, 1'b0, 20'h0, 1'b1, 1'b0, 20'd0,  rsf_pkg::KIND_JAL},
        // All-zero and all-one halfwords.
        '{16'h0000, 1'b0, 1'b0, 20'h0, 1'b1, 1'b0, 20'd0,  rsf_pkg::KIND_JAL},
        '{16'hffff, 1'b0, 1'b0, 20'h0, 1'b1, 1'b0, 20'd0,  rsf_pkg::KIND_JAL},
        '{16'hffff, 1'b0, 1'b0, 20'h0, 1'b1, 1'b0, 20'd0,  rsf_pkg::KIND_JAL},
        // A JAL cut off by the start of a new function is dropped.
        '{16'h006f, 1'b0, 1'b0, 20'h0, 1'b1, 1'b0, 20'd0,  rsf_pkg::KIND_JAL},
        '{16'h8082, 1'b1, 1'b0, 20'h0, 1'b1, 1'b1, 20'd0,  rsf_pkg::KIND_CJR},
        // Largest size: the most negative JAL still lands below zero.
        '{16'h006f, 1'b1, 1'b1, 20'hfffff, 1'b1, 1'b0, 20'd0, rsf_pkg::KIND_JAL},
        '{16'h8000, 1'b0, 1'b0, 20'h0, 1'b1, 1'b1, 20'd0,  rsf_pkg::KIND_JAL},
        '{16'ha001, 1'b0, 1'b0, 20'h0, 1'b1, 1'b0, 20'd0,  rsf_pkg::KIND_JAL},
        // C.J with the largest forward and backward displacements.
        '{16'haffd, 1'b0, 1'b0, 20'h0, 1'b0, 1'b0, 20'd0,  rsf_pkg::KIND_JAL},
        '{16'hb001, 1'b0, 1'b0, 20'h0, 1'b0, 1'b0, 20'd0,  rsf_pkg::KIND_JAL},
        // A JAL whose target sits exactly on the function's end.
        '{16'h006f, 1'b1, 1'b1, 20'h40, 1'b0, 1'b0, 20'd0, rsf_pkg::KIND_JAL},
        '{16'h0400, 1'b0, 1'b0, 20'h0, 1'b0, 1'b0, 20'd0,  rsf_pkg::KIND_JAL}
    };

    // Block ports. Every input starts at a known value.
    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              i_cfg_valid = 1'b0;
    logic                              o_cfg_ready;
    logic [rsf_pkg::SIZE_BITS-1:0]     i_cfg_data = '0;
    logic                              i_s_tvalid = 1'b0;
    logic                              o_s_tready;
    logic [rsf_pkg::IN_TDATA_W-1:0]    i_s_tdata = '0;     // [15:0] half
    logic [0:0]                        i_s_tuser = '0;     // [0] first
    logic                              o_m_tvalid;
    logic                              i_m_tready = 1'b0;
    logic [rsf_pkg::OUT_TDATA_W-1:0]   o_m_tdata;          // [19:0] ret_offset, [23:20] zero
    logic [rsf_pkg::KIND_BITS-1:0]     o_m_tuser;          // [1:0] exit_kind

    // Predictor state: the function size and the decoder's view of the code stream.
    logic [rsf_pkg::SIZE_BITS-1:0]   size_q = '0;
    logic [rsf_pkg::OFFSET_BITS-1:0] off_q = '0;
    logic                            pend_q = 1'b0;
    logic [rsf_pkg::HALF_BITS-1:0]   low_q = '0;

    // Exit sites predicted but not yet seen on the master stream, oldest first.
    t_exit_site exits_due[$];
    t_exit_site head;

    int          err_cnt = 0;
    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    int unsigned halves_sent = 0;
    int unsigned cycles = 0;

    riscv_return_site_finder u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

    always #1 i_clk = ~i_clk;

    // A jump target counts as outside when it falls below zero or at or past the size.
    // The target is taken from the wrapped offset and is not wrapped again.
    function automatic bit lands_outside(input logic [rsf_pkg::OFFSET_BITS-1:0] at,
                                         input longint disp);
        longint tgt;
        tgt = longint'(at) + disp;
        return (tgt < 0) || (tgt >= longint'(size_q));
    endfunction

    // Advances the predictor by one halfword and returns the exit it completes, if any.
    function automatic t_exit_site next_exit(input logic [rsf_pkg::HALF_BITS-1:0] h,
                                             input logic first);
        t_exit_site r;
        logic [rsf_pkg::OFFSET_BITS-1:0] at;
        logic [31:0] w;
        logic [rsf_pkg::JAL_IMM_BITS-1:0] jimm;
        logic [rsf_pkg::CJ_IMM_BITS-1:0] cimm;
        r = '{hit: 1'b0, off: '0, kind: rsf_pkg::KIND_JAL};
        // A new function restarts the offset and drops any half-built instruction.
        if (first) begin
            off_q = '0;
            pend_q = 1'b0;
        end
        at = off_q;
        if (pend_q) begin
            w = {h, low_q};
            pend_q = 1'b0;
            off_q = off_q + OFF_W'(rsf_pkg::STEP_WORD);
            if (w[6:0] == rsf_pkg::OPC_JAL) begin
                jimm = {w[31], w[19:12], w[20], w[30:21], 1'b0};
                if (w[11:7] != rsf_pkg::REG_RA
                        && lands_outside(at, longint'($signed(jimm))))
                    r = '{hit: 1'b1, off: RET_W'(at), kind: rsf_pkg::KIND_JAL};
            end else if ((w & rsf_pkg::MASK_JALR) == rsf_pkg::MATCH_JALR) begin
                if (w[11:7] != rsf_pkg::REG_RA || w[19:15] == rsf_pkg::REG_RA)
                    r = '{hit: 1'b1, off: RET_W'(at), kind: rsf_pkg::KIND_JALR};
            end
        end else if (h[1:0] == 2'b11) begin
            // Low half of a 32-bit instruction: held until its upper half arrives.
            low_q = h;
            pend_q = 1'b1;
        end else begin
            off_q = off_q + OFF_W'(rsf_pkg::STEP_HALF);
            if ((h & rsf_pkg::MASK_CJ) == rsf_pkg::MATCH_CJ) begin
                cimm = {h[12], h[8], h[10:9], h[6], h[7], h[2], h[11], h[5:3], 1'b0};
                if (lands_outside(at, longint'($signed(cimm))))
                    r = '{hit: 1'b1, off: RET_W'(at), kind: rsf_pkg::KIND_CJ};
            end else if ((h & rsf_pkg::MASK_CJR) == rsf_pkg::MATCH_CJR
                             && h[11:7] != rsf_pkg::REG_ZERO) begin
                r = '{hit: 1'b1, off: RET_W'(at), kind: rsf_pkg::KIND_CJR};
            end
        end
        return r;
    endfunction

    // Builds a random instruction, weighted towards the jumps the block looks for. Jump
    // displacements mostly land near the function so that both sides of the bound are hit.
    function automatic t_insn build_insn();
        t_insn r;
        int span;
        int disp;
        int unsigned sel;
        logic [20:0] imm;
        logic [4:0] rd;
        logic [4:0] rs1;
        span = int'(size_q) + 64;
        disp = int'($urandom_range(0, 2 * span)) - span;
        if ($urandom_range(0, 7) == 0)
            disp = int'($urandom);
        imm = disp[20:0];
        imm[0] = 1'b0;
        case ($urandom_range(0, 3))
            0: rd = rsf_pkg::REG_ZERO;
            1: rd = rsf_pkg::REG_RA;
            default: rd = 5'($urandom);
        endcase
        case ($urandom_range(0, 3))
            0: rs1 = rsf_pkg::REG_ZERO;
            1: rs1 = rsf_pkg::REG_RA;
            default: rs1 = 5'($urandom);
        endcase
        r.wide = 1'b1;
        r.word = $urandom;
        sel = $urandom_range(0, 99);
        if (sel < 25) begin
            // Any compressed instruction.
            r.wide = 1'b0;
            r.word[31:16] = '0;
            if (r.word[1:0] == 2'b11)
                r.word[1:0] = 2'($urandom_range(0, 2));
        end else if (sel < 40) begin
            r.wide = 1'b0;
            r.word = {16'h0, rsf_pkg::MATCH_CJ
                             | {3'b000, imm[11], imm[4], imm[9:8], imm[10], imm[6],
                                imm[7], imm[3:1], imm[5], 2'b00}};
        end else if (sel < 52) begin
            // C.JR, sometimes its C.MV or C.JALR neighbours.
            r.wide = 1'b0;
            r.word = {16'h0, rsf_pkg::MATCH_CJR
                             | {3'b000, ($urandom_range(0, 3) == 0), rs1,
                                ($urandom_range(0, 3) == 0) ? 5'($urandom)
                                                            : rsf_pkg::REG_ZERO,
                                2'b00}};
        end else if (sel < 70) begin
            r.word = {imm[20], imm[10:1], imm[11], imm[19:12], rd, rsf_pkg::OPC_JAL};
        end else if (sel < 85) begin
            r.word = rsf_pkg::MATCH_JALR | {12'($urandom), rs1,
                                            ($urandom_range(0, 5) == 0) ? 3'($urandom) : 3'b000,
                                            rd, 7'b0};
        end else begin
            r.word[1:0] = 2'b11;
        end
        return r;
    endfunction

    task automatic flag(input string what, input longint want, input longint got);
        err_cnt++;
        if (err_cnt <= MAX_SHOWN)
            $display("%0t ns: %s mismatch: expected %0h, got %0h", $time, what, want, got);
    endtask

    // Sends one halfword request, with a random idle gap in front of it, and records the
    // exit it should produce once the block has taken it.
    task automatic send_half(input logic [rsf_pkg::HALF_BITS-1:0] h, input logic first,
                             input logic typed = 1'b0, input t_exit_site want = '0);
        t_exit_site site;
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= h;
        i_s_tuser <= first;
        do @(posedge i_clk); while (!o_s_tready);
        halves_sent++;
        site = next_exit(h, first);
        if (typed)
            site = want;
        if (site.hit)
            exits_due.push_back(site);
    endtask

    task automatic send_insn(input t_insn ins, input logic first);
        send_half(ins.word[15:0], first);
        if (ins.wide)
            send_half(ins.word[31:16], 1'b0);
    endtask

    // Holds the sender back until every predicted exit has been seen, then gives the block a
    // settling time to finish halfwords that give no exit.
    task automatic settle();
        i_s_tvalid <= 1'b0;
        while (exits_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // func_size is only changed while the block is idle.
    task automatic write_size(input logic [rsf_pkg::SIZE_BITS-1:0] v);
        settle();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        size_q = v;
    endtask

    // The receiver drops tready at random, at the rate the current phase asks for.
    always @(posedge i_clk)
        i_m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);

    // Every result request taken by the receiver is matched with the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (exits_due.size() == 0) begin
                err_cnt++;
                if (err_cnt <= MAX_SHOWN)
                    $display("%0t ns: result with nothing expected: expected none, got %0h/%0d",
                             $time, o_m_tdata, o_m_tuser);
            end else begin
                head = exits_due.pop_front();
                if (o_m_tdata[rsf_pkg::RET_BITS-1:0] !== head.off)
                    flag("ret_offset", head.off, o_m_tdata[rsf_pkg::RET_BITS-1:0]);
                if (o_m_tdata[rsf_pkg::OUT_TDATA_W-1:rsf_pkg::RET_BITS] !== '0)
                    flag("tdata padding", 0,
                         o_m_tdata[rsf_pkg::OUT_TDATA_W-1:rsf_pkg::RET_BITS]);
                if (o_m_tuser !== head.kind)
                    flag("exit_kind", head.kind, o_m_tuser);
            end
        end
    end

    // Guard against a hang: a correct run ends far below this.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT_CYCLES) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        t_insn ins;
        int ph;
        int k;
        int len;
        int unsigned start;
        int unsigned blk_start;

        // Reset once, then the directed table with the sender lightly and the receiver
        // heavily throttled.
        tx_idle_pct = 7;
        rx_idle_pct = 79;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (k = 0; k < $size(DIRECTED); k++) begin
            if (DIRECTED[k].set_sz)
                write_size(DIRECTED[k].sz);
            send_half(DIRECTED[k].half, DIRECTED[k].first, DIRECTED[k].typed,
                      '{hit: DIRECTED[k].hit, off: DIRECTED[k].off, kind: DIRECTED[k].kind});
        end

        // Random part in three phases of idling. Each block of requests runs under one
        // function size; the write in front of it also makes the sender wait for the block
        // to drain completely.
        for (ph = 0; ph < 3; ph++) begin
            tx_idle_pct = (ph == 0) ? 7 : (ph == 1) ? 79 : 0;
            rx_idle_pct = (ph == 0) ? 79 : (ph == 1) ? 7 : 0;
            start = halves_sent;
            while (halves_sent - start < PHASE_ITEMS) begin
                case ($urandom_range(0, 5))
                    0: write_size('0);
                    1: write_size('1);
                    2, 3: write_size(SIZE_W'($urandom_range(2, 128)));
                    4: write_size(SIZE_W'($urandom_range(0, 4096)));
                    default: write_size(SIZE_W'($urandom));
                endcase
                blk_start = halves_sent;
                while (halves_sent - blk_start < BLOCK_ITEMS) begin
                    if ($urandom_range(0, 9) == 0) begin
                        // Noise: raw halfwords, now and then flagged as a function start.
                        repeat ($urandom_range(1, 12))
                            send_half(16'($urandom), ($urandom_range(0, 7) == 0));
                    end else begin
                        // A well-formed function body of random instructions.
                        len = $urandom_range(1, 30);
                        for (k = 0; k < len; k++)
                            send_insn(build_insn(), (k == 0));
                        // Sometimes the function ends in the middle of a 32-bit instruction.
                        if ($urandom_range(0, 9) == 0) begin
                            do ins = build_insn(); while (!ins.wide);
                            send_half(ins.word[15:0], 1'b0);
                        end
                    end
                end
            end
        end

        settle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (err_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> sim.f
hdl/rsf_pkg.sv
hdl/rsf_decode.sv
hdl/riscv_return_site_finder.sv
hdl/rsf_checker.sv
tb/tb_riscv_return_site_finder.sv
